// ===== rtl/core/fdu_pkg.sv =====
// ----------------------------------------------------------------------------
// Feature distance unit package
// Widths, metric codes, iterative unit operations and the request and result
// types shared by the feature distance unit and its submodules.
// ----------------------------------------------------------------------------
package fdu_pkg;

  // Feature and accumulator geometry.
  localparam int FEAT_W   = 16;
  localparam int ACC_W    = 48;
  localparam int OUT_W    = 49;
  localparam int ROOT_W   = ACC_W / 2;
  localparam int MUL_W    = ROOT_W;
  localparam int REM_W    = ACC_W + 2;
  localparam int DIV_BITS = 2 * FEAT_W;
  localparam int Q_FRAC   = 15;
  localparam int CNT_W    = $clog2(DIV_BITS + 1);

  // Configuration port.
  localparam int MODE_W    = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_METRIC_MODE = '0;

  // Metric codes held in the metric_mode register.
  localparam logic [MODE_W-1:0] MODE_SSD       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EUCLID    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COSINE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHI       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MANHATTAN = 3'd4;

  // Operations of the shared iterative unit.
  typedef enum logic [1:0] {
    OP_DIV   = 2'd0,
    OP_SQRT  = 2'd1,
    OP_RATIO = 2'd2
  } fdu_op_t;

  typedef struct packed {
    logic    start;
    fdu_op_t op;
  } fdu_iter_ctl_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature_a;
    logic signed [FEAT_W-1:0] feature_b;
    logic                     last_feature;
  } fdu_pair_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] distance_value;
    logic                    saturated;
    logic                    zero_divide;
  } fdu_result_t;

endpackage

// ===== rtl/core/feature_distance_unit.sv =====
// ----------------------------------------------------------------------------
// Feature distance unit
// Accumulates a distance between two feature vectors under a chosen metric.
// ----------------------------------------------------------------------------
// Each request carries one pair of signed Q8.8 features. The metric_mode
// register selects sum of squared differences, Euclidean distance, cosine
// ratio, chi-square or Manhattan sum; a request marked last still adds its own
// pair and then produces one result, after which every accumulator and flag is
// cleared. In cosine mode a request takes three products through the one
// multiplier, and in chi-square mode the shared iterative unit divides each
// term. A chi-square pair whose denominator is zero skips the division, as
// does any pair under a spare mode code. A last request then hands its result
// to the output register, after the finishing work on the same unit: the
// Euclidean root, or for cosine two roots and a 15-step ratio (the ratio is
// skipped when a root is zero or the ratio reaches one). The input is not
// ready while a request is being worked on. A finished result waits in the
// output register; only a later last request that reaches its hand-over while
// that result is still untaken is held up until it goes. Accumulators
// saturate and raise the saturated flag.
// ----------------------------------------------------------------------------
module feature_distance_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  fdu_pkg::fdu_pair_t             pair,
  input  logic                           pair_valid,
  output logic                           pair_ready,
  output fdu_pkg::fdu_result_t           result,
  output logic                           result_valid,
  input  logic                           result_ready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fdu_pkg::APB_AW-1:0]     paddr,
  input  logic [fdu_pkg::APB_DW-1:0]     pwdata,
  output logic [fdu_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import fdu_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE       = 11'h001,
    ST_MUL        = 11'h002,
    ST_DIV_GO     = 11'h004,
    ST_DIV_WAIT   = 11'h008,
    ST_ACC        = 11'h010,
    ST_ROOT_GO    = 11'h020,
    ST_ROOT_WAIT  = 11'h040,
    ST_PROD       = 11'h080,
    ST_RATIO_GO   = 11'h100,
    ST_RATIO_WAIT = 11'h200,
    ST_EMIT       = 11'h400
  } state_t;

  // Cosine terms, taken in this order through the multiplier.
  localparam logic [1:0] PH_FIRST_MAG  = 2'd0;
  localparam logic [1:0] PH_SECOND_MAG = 2'd1;
  localparam logic [1:0] PH_DOT        = 2'd2;

  localparam logic [Q_FRAC:0] COS_CAP = (Q_FRAC + 1)'(1 << Q_FRAC);
  localparam logic [Q_FRAC:0] COS_MAX = COS_CAP - (Q_FRAC + 1)'(1);

  state_t state, state_next, end_state;

  logic [MODE_W-1:0] metric_mode;
  logic [ACC_W-1:0]  main_sum;
  logic [ACC_W-1:0]  dot_sum;
  logic [ACC_W-1:0]  first_magnitude;
  logic [ACC_W-1:0]  second_magnitude;
  logic              saturation_seen;
  logic              zero_divide_seen;
  logic [1:0]        phase;
  logic              root_sel;

  // Request registers and datapath values.
  logic signed [FEAT_W-1:0] fa, fb;
  logic                     last_r;
  logic signed [FEAT_W:0]   diff_s, sum_s;
  logic [FEAT_W:0]          diff_abs, sum_mag, a_abs, b_abs;
  logic [FEAT_W-1:0]        dm, a_mag, b_mag;
  logic                     sum_zero;

  logic [MUL_W-1:0]  mul_x, mul_y;
  logic [ACC_W-1:0]  mul_full;
  logic [ACC_W-1:0]  prod;
  logic [ROOT_W-1:0] root1;
  logic              roots_zero;

  logic [ACC_W-1:0] acc_in, acc_term, acc_out;
  logic             acc_signed_op, acc_neg, acc_sat;
  logic [REM_W-1:0] add_a, add_b, add_sum;

  logic [ACC_W-1:0] dot_mag;
  logic             ratio_cap;
  logic [Q_FRAC:0]  cos_q;
  logic signed [Q_FRAC+1:0] cos_next, cos_value;
  logic [OUT_W-1:0] value;

  fdu_iter_ctl_t    iter_ctl;
  logic [ACC_W-1:0] iter_a, iter_b, iter_res;
  logic             iter_busy;

  logic accept, emit_fire, cfg_write;

  // --------------------------------------------------------------------------
  // Configuration port. Writes land on the access cycle; pready is tied high.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[APB_AW-1:2] == REG_METRIC_MODE);
  assign prdata    = (paddr[APB_AW-1:2] == REG_METRIC_MODE) ?
                     APB_DW'(metric_mode) : '0;

  assign pair_ready = (state == ST_IDLE);
  assign accept     = pair_valid && pair_ready;
  assign emit_fire  = (state == ST_EMIT) && (!result_valid || result_ready);

  // --------------------------------------------------------------------------
  // Per-pair arithmetic on the registered features. The difference and the sum
  // need one extra bit; their magnitudes fit the feature width except the
  // sum, which can reach 2^16 when both features are at the negative limit.
  // --------------------------------------------------------------------------
  always_comb begin
    diff_s   = (FEAT_W + 1)'(fa) - (FEAT_W + 1)'(fb);
    sum_s    = (FEAT_W + 1)'(fa) + (FEAT_W + 1)'(fb);
    diff_abs = diff_s[FEAT_W] ? -diff_s : diff_s;
    sum_mag  = sum_s[FEAT_W] ? -sum_s : sum_s;
    a_abs    = fa[FEAT_W-1] ? -(FEAT_W + 1)'(fa) : (FEAT_W + 1)'(fa);
    b_abs    = fb[FEAT_W-1] ? -(FEAT_W + 1)'(fb) : (FEAT_W + 1)'(fb);
    dm       = diff_abs[FEAT_W-1:0];
    a_mag    = a_abs[FEAT_W-1:0];
    b_mag    = b_abs[FEAT_W-1:0];
    sum_zero = (sum_s == '0);
  end

  // --------------------------------------------------------------------------
  // The one multiplier. In the accumulation phase it squares differences and
  // magnitudes and forms dot-product terms; it also multiplies the two roots
  // for the cosine divisor. Its product is always registered before use.
  // --------------------------------------------------------------------------
  always_comb begin
    mul_x = MUL_W'(dm);
    mul_y = MUL_W'(dm);
    if (state == ST_PROD) begin
      mul_x = root1;
      mul_y = iter_res[ROOT_W-1:0];
    end else if (metric_mode == MODE_COSINE) begin
      case (phase)
        PH_FIRST_MAG: begin
          mul_x = MUL_W'(a_mag);
          mul_y = MUL_W'(a_mag);
        end
        PH_SECOND_MAG: begin
          mul_x = MUL_W'(b_mag);
          mul_y = MUL_W'(b_mag);
        end
        default: begin
          mul_x = MUL_W'(a_mag);
          mul_y = MUL_W'(b_mag);
        end
      endcase
    end
  end

  assign mul_full = mul_x * mul_y;

  // --------------------------------------------------------------------------
  // Saturating accumulator adder. Unsigned sums clamp at all ones; the signed
  // chi-square and dot-product sums clamp at either end of the signed range.
  // The term arrives as a sign and a magnitude.
  // --------------------------------------------------------------------------
  always_comb begin
    acc_in        = main_sum;
    acc_term      = prod;
    acc_signed_op = 1'b0;
    acc_neg       = 1'b0;
    case (metric_mode)
      MODE_MANHATTAN: begin
        acc_term = ACC_W'(dm);
      end
      MODE_CHI: begin
        acc_term      = iter_res;
        acc_signed_op = 1'b1;
        acc_neg       = sum_s[FEAT_W];
      end
      MODE_COSINE: begin
        case (phase)
          PH_FIRST_MAG:  acc_in = first_magnitude;
          PH_SECOND_MAG: acc_in = second_magnitude;
          default: begin
            acc_in        = dot_sum;
            acc_signed_op = 1'b1;
            acc_neg       = fa[FEAT_W-1] ^ fb[FEAT_W-1];
          end
        endcase
      end
      default: begin
        acc_term = prod;
      end
    endcase

    add_a   = acc_signed_op ? REM_W'($signed(acc_in)) : REM_W'(acc_in);
    add_b   = acc_neg ? (REM_W'(0) - REM_W'(acc_term)) : REM_W'(acc_term);
    add_sum = add_a + add_b;

    if (acc_signed_op) begin
      acc_sat = (add_sum[REM_W-1:ACC_W-1] != '0) &&
                (add_sum[REM_W-1:ACC_W-1] != '1);
      if (!acc_sat) begin
        acc_out = add_sum[ACC_W-1:0];
      end else if (add_sum[REM_W-1]) begin
        acc_out = {1'b1, {(ACC_W - 1){1'b0}}};
      end else begin
        acc_out = {1'b0, {(ACC_W - 1){1'b1}}};
      end
    end else begin
      acc_sat = add_sum[ACC_W];
      acc_out = acc_sat ? '1 : add_sum[ACC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Cosine finishing: a ratio of one or more is capped before the unit runs,
  // then the quotient is clamped below one or negated with the dot product.
  // --------------------------------------------------------------------------
  always_comb begin
    dot_mag    = dot_sum[ACC_W-1] ? (ACC_W'(0) - dot_sum) : dot_sum;
    ratio_cap  = (dot_mag >= prod);
    roots_zero = (root1 == '0) || (iter_res[ROOT_W-1:0] == '0);
    cos_q      = (state == ST_RATIO_GO) ? COS_CAP : iter_res[Q_FRAC:0];
    if (dot_sum[ACC_W-1]) begin
      cos_next = -$signed({1'b0, cos_q});
    end else if (cos_q > COS_MAX) begin
      cos_next = $signed({1'b0, COS_MAX});
    end else begin
      cos_next = $signed({1'b0, cos_q});
    end
  end

  // --------------------------------------------------------------------------
  // Shared iterative unit: per-term division in chi-square mode, the final
  // roots and the cosine ratio.
  // --------------------------------------------------------------------------
  always_comb begin
    iter_ctl.start = (state == ST_DIV_GO) || (state == ST_ROOT_GO) ||
                     ((state == ST_RATIO_GO) && !ratio_cap);
    iter_ctl.op    = OP_RATIO;
    iter_a         = dot_mag;
    iter_b         = prod;
    if (state == ST_DIV_GO) begin
      iter_ctl.op = OP_DIV;
      iter_a      = prod;
      iter_b      = ACC_W'(sum_mag);
    end else if (state == ST_ROOT_GO) begin
      iter_ctl.op = OP_SQRT;
      if (metric_mode == MODE_EUCLID) begin
        iter_a = main_sum;
      end else begin
        iter_a = root_sel ? second_magnitude : first_magnitude;
      end
    end
  end

  fdu_iter u_iter (
    .clk       (clk),
    .rst       (rst),
    .ctl       (iter_ctl),
    .operand_a (iter_a),
    .operand_b (iter_b),
    .busy      (iter_busy),
    .result    (iter_res)
  );

  // --------------------------------------------------------------------------
  // Result value, read at the emit cycle from the mode current at that point.
  // --------------------------------------------------------------------------
  always_comb begin
    case (metric_mode)
      MODE_SSD, MODE_MANHATTAN: value = OUT_W'(main_sum);
      MODE_CHI:                 value = OUT_W'($signed(main_sum));
      MODE_EUCLID:              value = OUT_W'(iter_res);
      MODE_COSINE:              value = OUT_W'(cos_value);
      default:                  value = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    if (!last_r) begin
      end_state = ST_IDLE;
    end else if ((metric_mode == MODE_EUCLID) || (metric_mode == MODE_COSINE)) begin
      end_state = ST_ROOT_GO;
    end else begin
      end_state = ST_EMIT;
    end

    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pair_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        case (metric_mode)
          MODE_SSD, MODE_EUCLID, MODE_COSINE, MODE_MANHATTAN: state_next = ST_ACC;
          MODE_CHI: state_next = sum_zero ? end_state : ST_DIV_GO;
          default:  state_next = end_state;
        endcase
      end
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!iter_busy) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        if ((metric_mode == MODE_COSINE) && (phase != PH_DOT)) begin
          state_next = ST_MUL;
        end else begin
          state_next = end_state;
        end
      end
      ST_ROOT_GO: state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (!iter_busy) begin
          if (metric_mode != MODE_COSINE) begin
            state_next = ST_EMIT;
          end else if (!root_sel) begin
            state_next = ST_ROOT_GO;
          end else if (roots_zero) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_PROD;
          end
        end
      end
      ST_PROD: state_next = ST_RATIO_GO;
      ST_RATIO_GO: state_next = ratio_cap ? ST_EMIT : ST_RATIO_WAIT;
      ST_RATIO_WAIT: begin
        if (!iter_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      metric_mode      <= '0;
      main_sum         <= '0;
      dot_sum          <= '0;
      first_magnitude  <= '0;
      second_magnitude <= '0;
      saturation_seen  <= 1'b0;
      zero_divide_seen <= 1'b0;
      phase            <= PH_FIRST_MAG;
      root_sel         <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        metric_mode <= pwdata[MODE_W-1:0];
      end

      if (accept) begin
        phase    <= PH_FIRST_MAG;
        root_sel <= 1'b0;
      end

      if ((state == ST_MUL) && (metric_mode == MODE_CHI) && sum_zero) begin
        zero_divide_seen <= 1'b1;
      end

      if (state == ST_ACC) begin
        phase <= phase + 2'd1;
        if (acc_sat) begin
          saturation_seen <= 1'b1;
        end
        if (metric_mode == MODE_COSINE) begin
          case (phase)
            PH_FIRST_MAG:  first_magnitude  <= acc_out;
            PH_SECOND_MAG: second_magnitude <= acc_out;
            default:       dot_sum          <= acc_out;
          endcase
        end else begin
          main_sum <= acc_out;
        end
      end

      if ((state == ST_ROOT_WAIT) && !iter_busy) begin
        root_sel <= 1'b1;
        if ((metric_mode == MODE_COSINE) && root_sel && roots_zero) begin
          zero_divide_seen <= 1'b1;
        end
      end

      // A new result replaces the old one only once the old one has gone.
      if (emit_fire) begin
        result_valid     <= 1'b1;
        main_sum         <= '0;
        dot_sum          <= '0;
        first_magnitude  <= '0;
        second_magnitude <= '0;
        saturation_seen  <= 1'b0;
        zero_divide_seen <= 1'b0;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      fa     <= pair.feature_a;
      fb     <= pair.feature_b;
      last_r <= pair.last_feature;
    end

    if ((state == ST_MUL) || (state == ST_PROD)) begin
      prod <= mul_full;
    end

    if ((state == ST_ROOT_WAIT) && !iter_busy) begin
      if (!root_sel) begin
        root1 <= iter_res[ROOT_W-1:0];
      end else if (roots_zero) begin
        cos_value <= '0;
      end
    end

    if (((state == ST_RATIO_GO) && ratio_cap) ||
        ((state == ST_RATIO_WAIT) && !iter_busy)) begin
      cos_value <= cos_next;
    end

    if (emit_fire) begin
      result.distance_value <= value;
      result.saturated      <= saturation_seen;
      result.zero_divide    <= zero_divide_seen;
    end
  end

endmodule

// ===== rtl/core/fdu_iter.sv =====
// ----------------------------------------------------------------------------
// Shared iterative unit
// One compare and subtract step per cycle, used as a restoring divider, an
// integer square root and a fractional ratio generator.
// ----------------------------------------------------------------------------
module fdu_iter (
  input  logic                      clk,
  input  logic                      rst,
  input  fdu_pkg::fdu_iter_ctl_t    ctl,
  input  logic [fdu_pkg::ACC_W-1:0] operand_a,
  input  logic [fdu_pkg::ACC_W-1:0] operand_b,
  output logic                      busy,
  output logic [fdu_pkg::ACC_W-1:0] result
);
  import fdu_pkg::*;

  fdu_op_t          op;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] part;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic [ACC_W-1:0] src;
  logic [ACC_W-1:0] divisor;
  logic [ACC_W-1:0] quo;
  logic [CNT_W-1:0] count;
  logic             ge;

  // The square root brings in two radicand bits a step, the divider one.
  always_comb begin
    part  = {rem[REM_W-2:0], 1'b0};
    trial = {2'b00, divisor};
    case (op)
      OP_DIV: begin
        part = {rem[REM_W-2:0], src[ACC_W-1]};
      end
      OP_SQRT: begin
        part  = {rem[REM_W-3:0], src[ACC_W-1 -: 2]};
        trial = {quo, 2'b01};
      end
      OP_RATIO: begin
        part = {rem[REM_W-2:0], 1'b0};
      end
      default: begin
        part = {rem[REM_W-2:0], 1'b0};
      end
    endcase
    diff = part - trial;
    ge   = (part >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      case (ctl.op)
        OP_DIV:  count <= CNT_W'(DIV_BITS);
        OP_SQRT: count <= CNT_W'(ROOT_W);
        default: count <= CNT_W'(Q_FRAC);
      endcase
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op      <= ctl.op;
      quo     <= '0;
      divisor <= operand_b;
      case (ctl.op)
        OP_DIV: begin
          src <= operand_a << (ACC_W - DIV_BITS);
          rem <= '0;
        end
        OP_SQRT: begin
          src <= operand_a;
          rem <= '0;
        end
        default: begin
          src <= operand_a;
          rem <= {2'b00, operand_a};
        end
      endcase
    end else if (busy) begin
      rem <= ge ? diff : part;
      quo <= {quo[ACC_W-2:0], ge};
      src <= (op == OP_SQRT) ? (src << 2) : (src << 1);
    end
  end

  assign result = quo;

endmodule

// ===== rtl/core/fdu_checker.sv =====
// ----------------------------------------------------------------------------
// Feature distance unit checker
// Port-level assertions on the request and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
module fdu_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 pair_valid,
  input logic                 pair_ready,
  input fdu_pkg::fdu_result_t result,
  input logic                 result_valid,
  input logic                 result_ready
);

  // A result that is not taken holds still.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // The unit works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_ready |=> !pair_ready)
    else $error("request input ready straight after an accepted request");

  // A request needs at least its multiply cycle before any result appears.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_ready |=> !$rose(result_valid))
    else $error("result appeared one cycle after a request");

  // Reset leaves the unit empty and ready.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !result_valid && pair_ready)
    else $error("unit not empty and ready after reset");

endmodule

bind feature_distance_unit fdu_checker u_fdu_checker (.*);
